// ===== design/bffa_pkg.sv =====
// shared constants, status and request codes for the bitmap first-fit allocator
// no dependencies
`default_nettype none

package bffa_pkg;

  // bitmap digit handled per cycle
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned LOG_DIGIT = 3;

  // request and result field widths
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned BLK_W     = 3;
  localparam int unsigned CHUNK_W   = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned NEED_W    = SIZE_W - 1;  // ceil(size / 4)

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 16;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  // control from the sequencer to the run scanner
  typedef struct packed {
    logic eval;   // a bitmap digit is presented this cycle
    logic first;  // the digit is the first one of a block
  } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bitmap_first_fit_allocator.sv =====
// bitmap first-fit allocator top level: sequencer, bitmap ram, run scanner
// depends on bffa_pkg, bffa_ram, bffa_scan
// reset: a clearing pass writes MAX_BLOCKS*ceil(CHUNKS_PER_BLOCK/8) bitmap words, one per
//   cycle (256 words at default size), with s_axis_tready low; one block open afterwards
// allocate: the open blocks are scanned word by word, then the granted run is marked by
//   read-modify-write; when nothing fits a new block is opened, else no space is reported
// free: the run is cleared word by word; zero-size and rejected requests skip to the result
// one word in flight; s_axis_tready returns high in the same cycle that m_axis_tvalid rises,
//   and the result register lets the next word enter while the previous result waits
`default_nettype none

module bitmap_first_fit_allocator
  import bffa_pkg::*;
#(
  parameter int unsigned CHUNKS_PER_BLOCK = 256,
  parameter int unsigned MAX_BLOCKS       = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request side
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // size_bytes[15:0], block_index[18:16], chunk_index[26:19], zero pad
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // op[0]
  input  wire logic                 s_axis_tuser,
  // result side
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // status[1:0], granted_block[4:2], granted_chunk[12:5], zero pad
  output logic      [M_TDATA_W-1:0] m_axis_tdata
);

  // bitmap geometry
  localparam int unsigned WPB    = (CHUNKS_PER_BLOCK + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned DEPTH  = MAX_BLOCKS * WPB;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WOFF_W = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int unsigned CI_W   = WOFF_W + LOG_DIGIT;
  localparam int unsigned CNT_W  = $clog2(CHUNKS_PER_BLOCK + 1);
  localparam int unsigned BO_W   = $clog2(MAX_BLOCKS + 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  logic [BO_W-1:0]     blocks_open_q, blocks_open_d;

  // latched request
  logic                req_op_q, req_op_d;
  logic [NEED_W-1:0]   req_n_q, req_n_d;
  logic [BLK_W-1:0]    req_blk_q, req_blk_d;
  logic [CHUNK_W-1:0]  req_ch_q, req_ch_d;

  // scan read issue and evaluate stages
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic [WOFF_W-1:0]   rd_woff_q, rd_woff_d;
  logic [BO_W-1:0]     rd_blk_q, rd_blk_d;
  logic                ev_valid_q, ev_valid_d;
  logic [WOFF_W-1:0]   ev_woff_q, ev_woff_d;
  logic [BO_W-1:0]     ev_blk_q, ev_blk_d;

  // run marking
  logic                mk_set_q, mk_set_d;
  logic [BO_W-1:0]     mk_blk_q, mk_blk_d;
  logic [CI_W-1:0]     mk_start_q, mk_start_d;
  logic [CI_W-1:0]     mk_last_q, mk_last_d;
  logic [WOFF_W-1:0]   mk_rd_word_q, mk_rd_word_d;
  logic                mk_rd_act_q, mk_rd_act_d;
  logic                wr_valid_q, wr_valid_d;
  logic [WOFF_W-1:0]   wr_word_q, wr_word_d;
  logic [AW-1:0]       wr_addr_q, wr_addr_d;

  // result
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [BLK_W-1:0]     res_blk_q, res_blk_d;
  logic [CHUNK_W-1:0]   res_ch_q, res_ch_d;
  logic                 out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  // mark setup shared by free, scan hit and new block
  logic                setup_go;
  logic                setup_set;
  logic [BO_W-1:0]     setup_blk;
  logic [CI_W-1:0]     setup_start;

  // ram and scanner wiring
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DIGIT_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [DIGIT_W-1:0]  ram_rdata;
  logic [AW-1:0]       mk_base;
  logic [AW-1:0]       mk_rd_addr;
  logic [DIGIT_W-1:0]  mk_mask;
  logic [WOFF_W-1:0]   mk_first_w;
  logic [WOFF_W-1:0]   mk_last_w;
  scan_ctrl_t          scan_ctrl;
  logic                scan_hit;
  logic [CI_W-1:0]     scan_start;
  logic                issuing;
  logic                free_bad;
  logic [SIZE_W:0]     size_round;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // chunks = ceil(size / 4)
  assign size_round = {1'b0, s_axis_tdata[SIZE_W-1:0]} + (SIZE_W + 1)'(3);

  // scan keeps issuing reads until every open block was covered
  assign issuing = (rd_blk_q < blocks_open_q);

  assign free_bad = (32'(req_blk_q) >= 32'(blocks_open_q)) ||
                    (32'(req_blk_q) >= MAX_BLOCKS) ||
                    (32'(req_ch_q) >= CHUNKS_PER_BLOCK) ||
                    ((32'(req_ch_q) + 32'(req_n_q)) > CHUNKS_PER_BLOCK);

  // marking addresses: block base plus digit index
  assign mk_base    = AW'(mk_blk_q) * AW'(WPB);
  assign mk_rd_addr = mk_base + AW'(mk_rd_word_q);
  assign mk_first_w = mk_start_q[CI_W-1:LOG_DIGIT];
  assign mk_last_w  = mk_last_q[CI_W-1:LOG_DIGIT];

  // partial digits at the edges of the run
  always_comb begin
    for (int i = 0; i < DIGIT_W; i++) begin
      mk_mask[i] = ((wr_word_q != mk_first_w) ||
                    (LOG_DIGIT'(i) >= mk_start_q[LOG_DIGIT-1:0])) &&
                   ((wr_word_q != mk_last_w) ||
                    (LOG_DIGIT'(i) <= mk_last_q[LOG_DIGIT-1:0]));
    end
  end

  // the clearing pass owns the write port after reset
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == S_MARK) && wr_valid_q;
      ram_waddr = wr_addr_q;
      ram_wdata = mk_set_q ? (ram_rdata | mk_mask) : (ram_rdata & ~mk_mask);
    end
  end

  assign ram_raddr = (state_q == S_MARK) ? mk_rd_addr : rd_addr_q;

  assign scan_ctrl.eval  = (state_q == S_SCAN) && ev_valid_q;
  assign scan_ctrl.first = (ev_woff_q == '0);

  bffa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bffa_scan #(
    .CHUNKS_PER_BLOCK (CHUNKS_PER_BLOCK)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .digit_i (ram_rdata),
    .woff_i  (ev_woff_q),
    .need_i  (CNT_W'(req_n_q)),
    .hit_o   (scan_hit),
    .start_o (scan_start)
  );

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    blocks_open_d = blocks_open_q;
    req_op_d      = req_op_q;
    req_n_d       = req_n_q;
    req_blk_d     = req_blk_q;
    req_ch_d      = req_ch_q;
    rd_addr_d     = rd_addr_q;
    rd_woff_d     = rd_woff_q;
    rd_blk_d      = rd_blk_q;
    ev_valid_d    = ev_valid_q;
    ev_woff_d     = ev_woff_q;
    ev_blk_d      = ev_blk_q;
    mk_set_d      = mk_set_q;
    mk_blk_d      = mk_blk_q;
    mk_start_d    = mk_start_q;
    mk_last_d     = mk_last_q;
    mk_rd_word_d  = mk_rd_word_q;
    mk_rd_act_d   = mk_rd_act_q;
    wr_valid_d    = wr_valid_q;
    wr_word_d     = wr_word_q;
    wr_addr_d     = wr_addr_q;
    res_status_d  = res_status_q;
    res_blk_d     = res_blk_q;
    res_ch_d      = res_ch_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    setup_go      = 1'b0;
    setup_set     = 1'b1;
    setup_blk     = '0;
    setup_start   = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_op_d  = s_axis_tuser;
          req_n_d   = size_round[SIZE_W:2];
          req_blk_d = s_axis_tdata[SIZE_W +: BLK_W];
          req_ch_d  = s_axis_tdata[SIZE_W + BLK_W +: CHUNK_W];
          state_d   = S_CHECK;
        end
      end

      S_CHECK: begin
        res_status_d = ST_OK;
        res_blk_d    = '0;
        res_ch_d     = '0;
        if (req_op_q == OP_ALLOC) begin
          if (req_n_q == '0) begin
            // zero-size allocate succeeds at block 0, chunk 0
            state_d = S_DONE;
          end else if (32'(req_n_q) > CHUNKS_PER_BLOCK) begin
            res_status_d = ST_NOSPACE;
            state_d      = S_DONE;
          end else begin
            rd_addr_d  = '0;
            rd_woff_d  = '0;
            rd_blk_d   = '0;
            ev_valid_d = 1'b0;
            state_d    = S_SCAN;
          end
        end else begin
          if (free_bad) begin
            res_status_d = ST_BADFREE;
            state_d      = S_DONE;
          end else if (req_n_q == '0) begin
            state_d = S_DONE;
          end else begin
            setup_go    = 1'b1;
            setup_set   = 1'b0;
            setup_blk   = BO_W'(req_blk_q);
            setup_start = CI_W'(req_ch_q);
          end
        end
      end

      S_SCAN: begin
        // read one digit a cycle, evaluate it the cycle after
        ev_valid_d = issuing;
        ev_woff_d  = rd_woff_q;
        ev_blk_d   = rd_blk_q;
        if (issuing) begin
          rd_addr_d = rd_addr_q + AW'(1);
          if (rd_woff_q == WOFF_W'(WPB - 1)) begin
            rd_woff_d = '0;
            rd_blk_d  = rd_blk_q + BO_W'(1);
          end else begin
            rd_woff_d = rd_woff_q + WOFF_W'(1);
          end
        end
        if (ev_valid_q && scan_hit) begin
          setup_go    = 1'b1;
          setup_blk   = ev_blk_q;
          setup_start = scan_start;
          res_blk_d   = BLK_W'(ev_blk_q);
          res_ch_d    = CHUNK_W'(scan_start);
        end else if (!ev_valid_q && !issuing) begin
          if (32'(blocks_open_q) < MAX_BLOCKS) begin
            // nothing fits: open the next block, the run lands at its start
            setup_go      = 1'b1;
            setup_blk     = blocks_open_q;
            blocks_open_d = blocks_open_q + BO_W'(1);
            res_blk_d     = BLK_W'(blocks_open_q);
            res_ch_d      = '0;
          end else begin
            res_status_d = ST_NOSPACE;
            state_d      = S_DONE;
          end
        end
      end

      S_MARK: begin
        // read-modify-write, next read overlaps the current write
        if (mk_rd_act_q) begin
          wr_valid_d = 1'b1;
          wr_word_d  = mk_rd_word_q;
          wr_addr_d  = mk_rd_addr;
          if (mk_rd_word_q == mk_last_w) begin
            mk_rd_act_d = 1'b0;
          end else begin
            mk_rd_word_d = mk_rd_word_q + WOFF_W'(1);
          end
        end else begin
          wr_valid_d = 1'b0;
        end
        if (!mk_rd_act_q && !wr_valid_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = M_TDATA_W'({res_ch_q, res_blk_q, res_status_q});
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (setup_go) begin
      mk_set_d     = setup_set;
      mk_blk_d     = setup_blk;
      mk_start_d   = setup_start;
      mk_last_d    = CI_W'(16'(setup_start) + 16'(req_n_q) - 16'd1);
      mk_rd_word_d = setup_start[CI_W-1:LOG_DIGIT];
      mk_rd_act_d  = 1'b1;
      wr_valid_d   = 1'b0;
      state_d      = S_MARK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_addr_q    <= '0;
      blocks_open_q <= BO_W'(1);
      ev_valid_q    <= 1'b0;
      mk_rd_act_q   <= 1'b0;
      wr_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      blocks_open_q <= blocks_open_d;
      ev_valid_q    <= ev_valid_d;
      mk_rd_act_q   <= mk_rd_act_d;
      wr_valid_q    <= wr_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload and pointers, no reset needed
  always_ff @(posedge clk_i) begin
    req_op_q     <= req_op_d;
    req_n_q      <= req_n_d;
    req_blk_q    <= req_blk_d;
    req_ch_q     <= req_ch_d;
    rd_addr_q    <= rd_addr_d;
    rd_woff_q    <= rd_woff_d;
    rd_blk_q     <= rd_blk_d;
    ev_woff_q    <= ev_woff_d;
    ev_blk_q     <= ev_blk_d;
    mk_set_q     <= mk_set_d;
    mk_blk_q     <= mk_blk_d;
    mk_start_q   <= mk_start_d;
    mk_last_q    <= mk_last_d;
    mk_rd_word_q <= mk_rd_word_d;
    wr_word_q    <= wr_word_d;
    wr_addr_q    <= wr_addr_d;
    res_status_q <= res_status_d;
    res_blk_q    <= res_blk_d;
    res_ch_q     <= res_ch_d;
    out_data_q   <= out_data_d;
  end

endmodule

`default_nettype wire

// ===== design/bffa_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module bffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bffa_scan.sv =====
// free-run scanner: walks one bitmap digit per cycle and tracks the current run
// depends on bffa_pkg
`default_nettype none

module bffa_scan
  import bffa_pkg::*;
#(
  parameter int unsigned CHUNKS_PER_BLOCK = 256,
  localparam int unsigned WPB    = (CHUNKS_PER_BLOCK + DIGIT_W - 1) / DIGIT_W,
  localparam int unsigned WOFF_W = (WPB > 1) ? $clog2(WPB) : 1,
  localparam int unsigned CI_W   = WOFF_W + LOG_DIGIT,
  localparam int unsigned CNT_W  = $clog2(CHUNKS_PER_BLOCK + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scan_ctrl_t         ctrl_i,
  input  wire logic [DIGIT_W-1:0] digit_i,
  input  wire logic [WOFF_W-1:0]  woff_i,
  input  wire logic [CNT_W-1:0]   need_i,
  output logic                    hit_o,
  output logic      [CI_W-1:0]    start_o
);

  logic [CNT_W-1:0] run_q, run_d;

  always_comb begin
    logic [CNT_W-1:0] run;
    logic [CI_W-1:0]  chunk;
    logic             occ;
    run     = ctrl_i.first ? '0 : run_q;
    hit_o   = 1'b0;
    start_o = '0;
    chunk   = '0;
    occ     = 1'b0;
    for (int i = 0; i < DIGIT_W; i++) begin
      chunk = {woff_i, LOG_DIGIT'(i)};
      // chunks past the block end count as taken
      occ = digit_i[i] || ({1'b0, chunk} >= (CI_W + 1)'(CHUNKS_PER_BLOCK));
      run = occ ? '0 : run + CNT_W'(1);
      if (!hit_o && (run == need_i)) begin
        hit_o   = 1'b1;
        start_o = CI_W'({1'b0, chunk} + (CI_W + 1)'(1) - (CI_W + 1)'(need_i));
      end
    end
    run_d = ctrl_i.eval ? run : run_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bffa_checker.sv =====
// port-level checks for the bitmap first-fit allocator, bound to the top level
// depends on bffa_pkg and bitmap_first_fit_allocator
`default_nettype none

module bffa_checker
  import bffa_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a result word waiting on the sink holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // only defined status codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK) || (m_axis_tdata[1:0] == ST_NOSPACE) ||
                      (m_axis_tdata[1:0] == ST_BADFREE))
    else $error("undefined status code");

  // failed requests grant nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[12:2] == '0))
    else $error("grant fields set on a failed request");

  // one request at a time: the request side closes right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for bitmap_first_fit_allocator: directed corner cases, then
// random allocate/free traffic checked against an in-bench first-fit bitmap predictor
// depends on bffa_pkg and the allocator rtl
`default_nettype none

module testbench;
  import bffa_pkg::*;

  localparam int unsigned CHUNKS       = 256;
  localparam int unsigned BLOCKS       = 8;
  localparam int unsigned PHASES       = 11;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_CYCLES = 320;

  // one request word as the allocator sees it
  typedef struct packed {
    logic                op;
    logic [SIZE_W-1:0]   size;
    logic [BLK_W-1:0]    blk;
    logic [CHUNK_W-1:0]  chunk;
  } alloc_req_t;

  // one result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    blk;
    logic [CHUNK_W-1:0]  chunk;
  } grant_t;

  // a run handed out and not yet freed, kept so frees can be well formed
  typedef struct packed {
    logic [BLK_W-1:0]    blk;
    logic [CHUNK_W-1:0]  chunk;
    logic [SIZE_W-1:0]   size;
  } live_run_t;

  // predicts each result from its own bitmap copy and checks results in order
  class alloc_scoreboard;
    bit [CHUNKS-1:0] chunk_used [BLOCKS];
    int unsigned     open_blocks;
    grant_t          pending_grants[$];
    live_run_t       live_runs[$];
    int unsigned     mismatches, n_alloc, n_free, n_ok, n_nospace, n_badfree;

    function new();
      foreach (chunk_used[b]) chunk_used[b] = '0;
      open_blocks = 1;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    // lowest start of a free run of need chunks in one block
    function bit first_fit(input int unsigned blk, input int unsigned need,
                           output int unsigned start);
      int unsigned run;
      start = 0;
      run   = 0;
      if (need == 0) return 1'b1;
      for (int unsigned ch = 0; ch < CHUNKS; ch++) begin
        if (chunk_used[blk][ch]) begin
          run = 0;
        end else begin
          run++;
          if (run == need) begin
            start = ch + 1 - need;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void predict_grant(input alloc_req_t req);
      grant_t      g;
      int unsigned need, start, b;
      bit          found;
      g     = '{status: ST_OK, blk: '0, chunk: '0};
      need  = (32'(req.size) + 3) / 4;
      found = 1'b0;
      start = 0;
      if (req.op == OP_ALLOC) begin
        n_alloc++;
        if (need <= CHUNKS) begin
          for (b = 0; b < open_blocks && !found; b++) begin
            if (first_fit(b, need, start)) begin
              found = 1'b1;
              g.blk = BLK_W'(b);
            end
          end
          // nothing fits in the open blocks: open one more while allowed
          if (!found && open_blocks < BLOCKS) begin
            b = open_blocks;
            open_blocks++;
            if (first_fit(b, need, start)) begin
              found = 1'b1;
              g.blk = BLK_W'(b);
            end
          end
        end
        if (found) begin
          for (int unsigned i = 0; i < need; i++) chunk_used[g.blk][start + i] = 1'b1;
          g.chunk = CHUNK_W'(start);
          if (need > 0) live_runs.push_back('{blk: g.blk, chunk: g.chunk, size: req.size});
        end else begin
          g.status = ST_NOSPACE;
          g.blk    = '0;
        end
      end else begin
        n_free++;
        if (32'(req.blk) >= open_blocks || 32'(req.chunk) >= CHUNKS ||
            32'(req.chunk) + need > CHUNKS) begin
          g.status = ST_BADFREE;
        end else begin
          for (int unsigned i = 0; i < need; i++) chunk_used[req.blk][req.chunk + i] = 1'b0;
        end
      end
      case (g.status)
        ST_OK:      n_ok++;
        ST_NOSPACE: n_nospace++;
        default:    n_badfree++;
      endcase
      pending_grants.push_back(g);
    endfunction

    task check_grant(input logic [M_TDATA_W-1:0] word);
      grant_t got, want;
      got.status = word[1:0];
      got.blk    = word[4:2];
      got.chunk  = word[12:5];
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("result word %h with no request outstanding", word));
        return;
      end
      want = pending_grants.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.blk !== want.blk)
        report_mismatch($sformatf("granted block %0d, predicted %0d", got.blk, want.blk));
      if (got.chunk !== want.chunk)
        report_mismatch($sformatf("granted chunk %0d, predicted %0d", got.chunk, want.chunk));
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // size_bytes[15:0], block_index[18:16], chunk_index[26:19], zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // op[0]
  logic                 s_axis_tuser  = OP_ALLOC;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // status[1:0], granted_block[4:2], granted_chunk[12:5], zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;

  alloc_scoreboard sb;

  // idling switches per phase, and the one-off long result hold-off
  bit idle_s        = 1'b0;
  bit idle_m        = 1'b0;
  bit hold_results  = 1'b0;

  bitmap_first_fit_allocator #(
    .CHUNKS_PER_BLOCK(CHUNKS),
    .MAX_BLOCKS      (BLOCKS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // offer one request word, after a random gap when idling is on; valid stays high
  // after the handshake so a back-to-back word needs no second assignment
  task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                              input logic [BLK_W-1:0] blk, input logic [CHUNK_W-1:0] chunk);
    alloc_req_t  req;
    int unsigned gap;
    req = '{op: op, size: size, blk: blk, chunk: chunk};
    gap = idle_s ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W-27){1'b0}}, chunk, blk, size};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_grant(req);
  endtask

  // result side: random stalls per word, plus one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end
      gap = idle_m ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // sample accepted result words on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_grant(m_axis_tdata);
  end

  initial begin
    int unsigned phase, k, roll, alloc_pct, pick, sz_roll;
    logic [SIZE_W-1:0] sz;
    live_run_t run;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero size, small fits, oversize, whole-block runs, bad frees
    send_request(OP_ALLOC, 16'd0, 3'd0, 8'd0);       // zero size grants block 0 chunk 0
    send_request(OP_ALLOC, 16'd1, 3'd0, 8'd0);
    send_request(OP_ALLOC, 16'd4, 3'd0, 8'd0);
    send_request(OP_ALLOC, 16'd5, 3'd0, 8'd0);       // rounds up to two chunks
    send_request(OP_ALLOC, 16'hffff, 3'd0, 8'd0);    // oversized, opens nothing
    send_request(OP_ALLOC, 16'd1024, 3'd7, 8'd255);  // whole block, opens block 1
    send_request(OP_ALLOC, 16'd1021, 3'd0, 8'd0);    // whole block, opens block 2
    send_request(OP_ALLOC, 16'd1025, 3'd0, 8'd0);    // one chunk too many
    send_request(OP_FREE, 16'd4, 3'd7, 8'd0);        // block not open
    send_request(OP_FREE, 16'd4, 3'd0, 8'd255);      // run ends at block end, never allocated
    send_request(OP_FREE, 16'd8, 3'd0, 8'd255);      // run passes block end
    send_request(OP_FREE, 16'd0, 3'd0, 8'd0);        // zero-size free
    send_request(OP_FREE, 16'd1024, 3'd1, 8'd0);     // whole block 1 back
    send_request(OP_FREE, 16'd4, 3'd0, 8'd1);        // hole at chunk 1
    send_request(OP_ALLOC, 16'd4, 3'd0, 8'd0);       // first fit lands in that hole
    send_request(OP_FREE, 16'd4, 3'd3, 8'd0);        // block 3 still closed
    send_request(OP_FREE, 16'hffff, 3'd0, 8'd0);     // huge free runs off the end
    // whole-block runs fill every empty block, the last of the seven finds no room
    repeat (7) send_request(OP_ALLOC, 16'd1024, 3'd0, 8'd0);
    send_request(OP_ALLOC, 16'd3, 3'd0, 8'd0);

    // random: phases alternate between filling and draining the pool
    for (phase = 0; phase < PHASES; phase++) begin
      alloc_pct = (phase % 2 == 0) ? 75 : 35;
      idle_s    = ($urandom_range(0, 3) != 0);
      idle_m    = ($urandom_range(0, 3) != 0);
      if (phase == PHASES / 2) hold_results = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll >= 90) begin
          // noise: arbitrary free, often bad or clearing someone else's chunks
          sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 65535))
                                           : SIZE_W'($urandom_range(0, 128));
          send_request(OP_FREE, sz, BLK_W'($urandom_range(0, 7)),
                       CHUNK_W'($urandom_range(0, 255)));
        end else if (roll < alloc_pct || sb.live_runs.size() == 0) begin
          // mostly small sizes, a few whole blocks and the odd oversize one
          sz_roll = $urandom_range(0, 99);
          if (sz_roll < 2)       sz = '0;
          else if (sz_roll < 70) sz = SIZE_W'($urandom_range(1, 64));
          else if (sz_roll < 88) sz = SIZE_W'($urandom_range(65, 400));
          else if (sz_roll < 97) sz = SIZE_W'($urandom_range(401, 1024));
          else                   sz = SIZE_W'($urandom_range(0, 65535));
          send_request(OP_ALLOC, sz, BLK_W'($urandom_range(0, 7)),
                       CHUNK_W'($urandom_range(0, 255)));
        end else begin
          // well formed: hand back a run that was granted earlier
          pick = $urandom_range(0, sb.live_runs.size() - 1);
          run  = sb.live_runs[pick];
          sb.live_runs.delete(pick);
          send_request(OP_FREE, run.size, run.blk, run.chunk);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d allocations and %0d frees, %0d of %0d blocks opened",
             sb.n_alloc, sb.n_free, sb.open_blocks, BLOCKS);
    $display("results: %0d ok, %0d no space, %0d bad free",
             sb.n_ok, sb.n_nospace, sb.n_badfree);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", sb.pending_grants.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== bitmap_first_fit_allocator.f =====
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_scan.sv
design/bitmap_first_fit_allocator.sv
design/bffa_checker.sv
test/testbench.sv
